// ----- rtl/url_percent_codec_macros.svh -----
// Assertion macros for the codec's top module.
`ifndef URL_PERCENT_CODEC_MACROS_SVH
`define URL_PERCENT_CODEC_MACROS_SVH

`ifndef SYNTHESIS

`define UPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Implication check failed.");

`define UPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`else

`define UPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define UPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/upc_pkg.sv -----
package upc_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] REG_MODE_ADDR = 3'd0;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_LT      = 8'd60;
    localparam logic [7:0] CH_GT      = 8'd62;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       dvalid;
        logic       last;
        logic [1:0] phase;
        logic [7:0] high;
    } t_step;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        c = {4'b0000, nib} + CH_ZERO;
        if (c > CH_NINE) begin
            c = c + 8'd7;
        end
        return c;
    endfunction

    function automatic logic [7:0] digit_value(input logic [7:0] b);
        logic signed [7:0] v;
        v = b;
        if (v > 8'sd96) begin
            v = v - 8'sd32;
        end
        v = v - 8'sd48;
        if (v > 8'sd16) begin
            v = v - 8'sd7;
        end
        return v;
    endfunction

endpackage

// ----- rtl/upc_step.sv -----
module upc_step (
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_mode,
    input  logic [1:0]    i_phase,
    input  logic [7:0]    i_high,
    output upc_pkg::t_step o_step
);
    import upc_pkg::*;

    logic [7:0] w_dec_byte;
    logic [7:0] w_digit;
    logic       w_needs_esc;

    assign w_dec_byte  = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;
    assign w_digit     = digit_value(w_dec_byte);
    assign w_needs_esc = (i_byte < CH_ZERO) || ((i_byte >= CH_LT) && (i_byte <= CH_GT));

    always_comb begin
        o_step        = '0;
        o_step.phase  = i_phase;
        o_step.high   = i_high;
        o_step.dvalid = 1'b1;
        o_step.last   = i_last;
        if (i_mode == MODE_ENC) begin
            if (w_needs_esc) begin
                o_step.b0  = CH_PERCENT;
                o_step.b1  = hex_char(i_byte[7:4]);
                o_step.b2  = hex_char(i_byte[3:0]);
                o_step.cnt = 2'd3;
            end else begin
                o_step.b0  = i_byte;
                o_step.cnt = 2'd1;
            end
        end else begin
            case (i_phase)
                PH_IDLE: begin
                    if (w_dec_byte == CH_PERCENT) begin
                        if (i_last) begin
                            o_step.dvalid = 1'b0;
                            o_step.cnt    = 2'd1;
                        end else begin
                            o_step.phase = PH_HIGH;
                        end
                    end else begin
                        o_step.b0  = w_dec_byte;
                        o_step.cnt = 2'd1;
                    end
                end
                PH_HIGH: begin
                    if (i_last) begin
                        o_step.dvalid = 1'b0;
                        o_step.cnt    = 2'd1;
                        o_step.phase  = PH_IDLE;
                        o_step.high   = '0;
                    end else begin
                        o_step.high  = w_digit;
                        o_step.phase = PH_LOW;
                    end
                end
                default: begin
                    o_step.b0    = {i_high[3:0], 4'b0000} + w_digit;
                    o_step.cnt   = 2'd1;
                    o_step.phase = PH_IDLE;
                    o_step.high  = '0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/url_percent_codec.sv -----
// Channel   Handshake                  Payload
// in        i_in_valid / o_in_stall    i_in_byte, i_in_last
// out       o_res_valid / i_res_stall  o_out_byte, o_out_valid, o_out_last
// cfg       psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// A byte that yields one result, or none, is taken in every cycle unless the output
// stalls; the result appears in the cycle after its beat. An encoded escape gives three
// results that shift out through the output register, so the input stalls behind them.
// Reset is synchronous on i_rst_n, clears mode and escape state and empties the output buffer.
// The input is stalled only while results beyond the one leaving this cycle remain.
`include "url_percent_codec_macros.svh"

module url_percent_codec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_in_byte,
    input  logic                       i_in_last,
    output logic                       o_res_valid,
    input  logic                       i_res_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_out_valid,
    output logic                       o_out_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [upc_pkg::ADDR_W-1:0] paddr,
    input  logic [upc_pkg::DATA_W-1:0] pwdata,
    output logic [upc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import upc_pkg::*;

    logic       r_mode;
    logic [1:0] r_phase;
    logic [7:0] r_high;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic [7:0] r_b2;
    logic [1:0] r_cnt;
    logic       r_dvalid;
    logic       r_last;

    logic       w_take;
    logic       w_free;
    logic       w_accept;
    logic       w_cfg_wr;
    t_step      w_step;

    upc_step u_step (
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .i_mode  (r_mode),
        .i_phase (r_phase),
        .i_high  (r_high),
        .o_step  (w_step)
    );

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_MODE_ADDR) ? {{(DATA_W-1){1'b0}}, r_mode} : '0;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == REG_MODE_ADDR);

    assign o_res_valid = (r_cnt != 2'd0);
    assign o_out_byte  = r_b0;
    assign o_out_valid = r_dvalid;
    assign o_out_last  = r_last && (r_cnt == 2'd1);

    assign w_take     = o_res_valid && !i_res_stall;
    assign w_free     = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_take);
    assign o_in_stall = !w_free;
    assign w_accept   = i_in_valid && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENC;
            r_phase <= PH_IDLE;
            r_high  <= '0;
        end else if (w_cfg_wr) begin
            r_mode  <= pwdata[0];
            r_phase <= PH_IDLE;
            r_high  <= '0;
        end else if (w_accept) begin
            r_phase <= w_step.phase;
            r_high  <= w_step.high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_accept) begin
            r_cnt <= w_step.cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b0     <= w_step.b0;
            r_b1     <= w_step.b1;
            r_b2     <= w_step.b2;
            r_dvalid <= w_step.dvalid;
            r_last   <= w_step.last;
        end else if (w_take) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
        end
    end

    `UPC_ASSERT_IMP(a_marker_last, i_clk, i_rst_n, o_res_valid && !o_out_valid, o_out_last)
    `UPC_ASSERT_IMP(a_marker_zero, i_clk, i_rst_n, o_res_valid && !o_out_valid, o_out_byte == 8'd0)
    `UPC_ASSERT_IMP(a_empty_no_stall, i_clk, i_rst_n, !o_res_valid, !o_in_stall)
    `UPC_ASSERT_IMP(a_enc_no_escape, i_clk, i_rst_n, r_mode == MODE_ENC, r_phase == PH_IDLE)
    `UPC_ASSERT_NXT(a_enc_result, i_clk, i_rst_n, w_accept && (r_mode == MODE_ENC) && !w_cfg_wr, o_res_valid)

endmodule
